>>> hdl/rdse_pkg.sv
// Package for the radix digit string encoder.
// Holds field widths, the controller state type, the divider status struct
// and the digit-to-ASCII mapping. No dependencies.
`timescale 1ns / 1ps

package rdse_pkg;

  // Payload widths
  localparam int VALUE_W = 63;
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  // Digit stack depth default and line break position (digit index, MSD first)
  localparam int MAX_DIGITS_DEF = 64;
  localparam int LINE_BREAK_AT  = 44;

  // Serial divider: quotient bits retired per cycle, padded shift width
  localparam int DIV_STEPS  = 8;
  localparam int SHIFT_W    = ((VALUE_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIV_CYC    = SHIFT_W / DIV_STEPS;
  localparam int DIV_CNT_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  // Base limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(62);

  // Character codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] ZERO_CODE    = CHAR_W'(0);
  localparam logic [CHAR_W-1:0] ASCII_DIGIT0 = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_LOWER  = CHAR_W'(97);
  localparam logic [CHAR_W-1:0] ASCII_UPPER  = CHAR_W'(65);

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ZERO,
    S_DIV,
    S_FETCH,
    S_EMIT
  } state_e;

  // Divider status, one pulse per extracted digit
  typedef struct packed {
    logic               vld;
    logic [RADIX_W-1:0] digit;
    logic               last;
  } div_stat_t;

  // Map a digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (d <= RADIX_W'(9)) begin
      digit_char = ASCII_DIGIT0 + dx;
    end else if (d <= RADIX_W'(35)) begin
      digit_char = ASCII_LOWER + dx - CHAR_W'(10);
    end else begin
      digit_char = ASCII_UPPER + dx - CHAR_W'(36);
    end
  endfunction

endpackage

>>> hdl/rdse_if.sv
// Channel interfaces of the radix digit string encoder: input and result.
// Depends on rdse_pkg for the payload widths.
`timescale 1ns / 1ps

interface rdse_in_if;
  logic                         valid;
  logic                         ready;
  logic [rdse_pkg::VALUE_W-1:0] value;
  logic [rdse_pkg::RADIX_W-1:0] radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rdse_out_if;
  logic                        valid;
  logic                        ready;
  logic [rdse_pkg::CHAR_W-1:0] char_code;
  logic                        is_last;
  logic                        is_empty;

  modport source (output valid, output char_code, output is_last, output is_empty,
                  input ready);
  modport sink   (input valid, input char_code, input is_last, input is_empty,
                  output ready);
endinterface

>>> hdl/rdse_divider.sv
// Serial repeated divider: splits a value into digits of a given base,
// least significant first, DIV_STEPS quotient bits per cycle.
// Depends on rdse_pkg.
`timescale 1ns / 1ps

module rdse_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rdse_pkg::VALUE_W-1:0] value_i,
  input  logic [rdse_pkg::RADIX_W-1:0] radix_i,
  output rdse_pkg::div_stat_t          stat_o
);

  localparam int SW = rdse_pkg::SHIFT_W;
  localparam int RW = rdse_pkg::RADIX_W;
  localparam int NW = rdse_pkg::DIV_CNT_W;

  logic                            run_q;
  logic [NW-1:0]                   cnt_q;
  logic [SW-1:0]                   sh_q,  sh_d;
  logic [RW-1:0]                   rem_q, rem_d;
  logic [RW-1:0]                   radix_q;
  logic                            qnz_q, qnz_d;
  logic                            vld_q;
  logic [RW-1:0]                   digit_q;
  logic                            last_q;
  logic                            cnt_end;

  // Restoring division, DIV_STEPS bits per cycle; quotient bits enter at the bottom
  always_comb begin
    logic [RW:0] part;
    sh_d  = sh_q;
    rem_d = rem_q;
    qnz_d = qnz_q;
    for (int i = 0; i < rdse_pkg::DIV_STEPS; i++) begin
      part = {rem_d, sh_d[SW-1]};
      sh_d = {sh_d[SW-2:0], 1'b0};
      if (part >= {1'b0, radix_q}) begin
        part    = part - {1'b0, radix_q};
        sh_d[0] = 1'b1;
        qnz_d   = 1'b1;
      end
      rem_d = part[RW-1:0];
    end
  end

  assign cnt_end = (cnt_q == NW'(rdse_pkg::DIV_CYC - 1));

  // Control: run until a digit leaves a zero quotient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_end ? '0 : cnt_q + NW'(1);
        if (cnt_end) begin
          vld_q <= 1'b1;
          if (!qnz_d) begin
            run_q <= 1'b0;
          end
        end
      end
    end
  end

  // Datapath: hold the working quotient and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q    <= {{(SW-rdse_pkg::VALUE_W){1'b0}}, value_i};
      radix_q <= radix_i;
      rem_q   <= '0;
      qnz_q   <= 1'b0;
    end else if (run_q) begin
      sh_q <= sh_d;
      if (cnt_end) begin
        digit_q <= rem_d;
        last_q  <= !qnz_d;
        rem_q   <= '0;
        qnz_q   <= 1'b0;
      end else begin
        rem_q <= rem_d;
        qnz_q <= qnz_d;
      end
    end
  end

  assign stat_o = '{vld: vld_q, digit: digit_q, last: last_q};

endmodule

>>> hdl/radix_digit_string_encoder_core.sv
// Top level of the radix digit string encoder: digit stack, emit sequencer
// and output register around the serial divider.
// Depends on rdse_pkg, rdse_if and rdse_divider.
//
//   Port    | Dir | Payload                          | Transaction
//   --------+-----+----------------------------------+---------------------------------
//   in_i    | in  | value[62:0], radix[5:0]          | one number to convert
//   out_o   | out | char_code[6:0], is_last, is_empty| one ASCII character (or empty mark)
//
// Each digit is extracted by the serial divider, which retires 8 quotient bits
// per cycle over a 64-bit shift register; each character then passes through
// the stack read port (S_FETCH, then S_EMIT), while the newline is emitted
// straight from S_EMIT. A zero goes to S_ZERO, which emits one empty mark.
// One item at a time: in_i is ready only when idle; the last character may
// still sit in the output register while the next item is accepted.
// Reset clears all control state; the digit stack needs no clearing.
`timescale 1ns / 1ps

module radix_digit_string_encoder_core #(
  parameter int MAX_DIGITS = rdse_pkg::MAX_DIGITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rdse_in_if.sink    in_i,
  rdse_out_if.source out_o
);

  localparam int ADDR_W = $clog2(MAX_DIGITS);
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int RW     = rdse_pkg::RADIX_W;
  localparam int CW     = rdse_pkg::CHAR_W;

  rdse_pkg::state_e    state_q, state_d;
  rdse_pkg::div_stat_t div_stat;

  logic [RW-1:0]     stack_mem [MAX_DIGITS];
  logic [RW-1:0]     rd_data_q;
  logic [ADDR_W-1:0] rd_addr;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic              nl_q,  nl_d;
  logic [RW-1:0]     radix_clamp;
  logic              in_acc;
  logic              div_start;
  logic              push;
  logic              out_free;
  logic              pos_is_last;
  logic              pos_is_break;

  logic              out_vld_q;
  logic [CW-1:0]     out_char_q, out_char_d;
  logic              out_last_q, out_last_d;
  logic              out_empty_q, out_empty_d;
  logic              out_load;

  // Clamp the base into its legal range
  always_comb begin
    if (in_i.radix < rdse_pkg::RADIX_MIN) begin
      radix_clamp = rdse_pkg::RADIX_MIN;
    end else if (in_i.radix > rdse_pkg::RADIX_MAX) begin
      radix_clamp = rdse_pkg::RADIX_MAX;
    end else begin
      radix_clamp = in_i.radix;
    end
  end

  assign in_i.ready = (state_q == rdse_pkg::S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign div_start  = in_acc && (in_i.value != '0);

  rdse_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .value_i (in_i.value),
    .radix_i (radix_clamp),
    .stat_o  (div_stat)
  );

  assign out_free     = !out_vld_q || out_o.ready;
  assign push         = (state_q == rdse_pkg::S_DIV) && div_stat.vld &&
                        (cnt_q < CNT_W'(MAX_DIGITS));
  assign rd_addr      = ADDR_W'(cnt_q - pos_q - CNT_W'(1));
  assign pos_is_last  = ((pos_q + CNT_W'(1)) == cnt_q);
  assign pos_is_break = (pos_q == CNT_W'(rdse_pkg::LINE_BREAK_AT));

  // Digit stack: push in extraction order, read top-down with registered data
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[cnt_q[ADDR_W-1:0]] <= div_stat.digit;
    end
    rd_data_q <= stack_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rdse_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (in_i.value == '0) ? rdse_pkg::S_ZERO : rdse_pkg::S_DIV;
        end
      end
      rdse_pkg::S_ZERO: begin
        if (out_free) begin
          state_d = rdse_pkg::S_IDLE;
        end
      end
      rdse_pkg::S_DIV: begin
        if (div_stat.vld && div_stat.last) begin
          state_d = rdse_pkg::S_FETCH;
        end
      end
      rdse_pkg::S_FETCH: begin
        state_d = rdse_pkg::S_EMIT;
      end
      rdse_pkg::S_EMIT: begin
        if (out_free && !(pos_is_break && !nl_q)) begin
          state_d = pos_is_last ? rdse_pkg::S_IDLE : rdse_pkg::S_FETCH;
        end
      end
      default: state_d = rdse_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: counters and output register load
  always_comb begin
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    nl_d        = nl_q;
    out_load    = 1'b0;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    unique case (state_q)
      rdse_pkg::S_IDLE: begin
        if (in_acc) begin
          cnt_d = '0;
          pos_d = '0;
          nl_d  = 1'b0;
        end
      end
      rdse_pkg::S_ZERO: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_char_d  = rdse_pkg::ZERO_CODE;
          out_last_d  = 1'b1;
          out_empty_d = 1'b1;
        end
      end
      rdse_pkg::S_DIV: begin
        if (push) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      rdse_pkg::S_FETCH: begin
      end
      rdse_pkg::S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_empty_d = 1'b0;
          if (pos_is_break && !nl_q) begin
            out_char_d = rdse_pkg::NEWLINE_CODE;
            out_last_d = 1'b0;
            nl_d       = 1'b1;
          end else begin
            out_char_d = rdse_pkg::digit_char(rd_data_q);
            out_last_d = pos_is_last;
            pos_d      = pos_q + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rdse_pkg::S_IDLE;
      cnt_q     <= '0;
      pos_q     <= '0;
      nl_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      nl_q    <= nl_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.char_code = out_char_q;
  assign out_o.is_last   = out_last_q;
  assign out_o.is_empty  = out_empty_q;

endmodule

>>> verif/rdse_checker.sv
// Checker for the radix digit string encoder: watches the number and character
// channels, predicts the character string of every accepted number and
// compares each character transaction. Depends on rdse_pkg and rdse_if.
`timescale 1ns / 1ps

module rdse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rdse_in_if          in_mon_i,
  rdse_out_if         out_mon_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  localparam int VW = rdse_pkg::VALUE_W;
  localparam int RW = rdse_pkg::RADIX_W;
  localparam int CW = rdse_pkg::CHAR_W;

  typedef struct packed {
    logic [CW-1:0] char_code;
    logic          is_last;
    logic          is_empty;
  } char_t;

  // Characters still owed by the block, oldest first
  char_t       owed_chars[$];
  int unsigned mismatches = 0;

  // Split a number into digits and queue its characters, most significant first
  function automatic void queue_digit_string(input logic [VW-1:0] number,
                                             input logic [RW-1:0] radix);
    logic [VW-1:0] quot;
    logic [VW-1:0] base;
    logic [RW-1:0] digits [64];
    logic [RW-1:0] dig;
    int            n_dig;
    char_t         c;
    // Clamp the base into its legal range
    if (radix < rdse_pkg::RADIX_MIN) base = VW'(rdse_pkg::RADIX_MIN);
    else if (radix > rdse_pkg::RADIX_MAX) base = VW'(rdse_pkg::RADIX_MAX);
    else base = VW'(radix);
    // Zero writes no digits: one empty mark
    if (number == '0) begin
      c.char_code = rdse_pkg::ZERO_CODE;
      c.is_last   = 1'b1;
      c.is_empty  = 1'b1;
      owed_chars.push_back(c);
      return;
    end
    // Least significant digit lands at index 0
    quot  = number;
    n_dig = 0;
    while (quot != '0) begin
      digits[n_dig] = RW'(quot % base);
      quot          = quot / base;
      n_dig++;
    end
    for (int i = 0; i < n_dig; i++) begin
      // Newline goes in front of the digit at the break position
      if (i == rdse_pkg::LINE_BREAK_AT) begin
        c.char_code = rdse_pkg::NEWLINE_CODE;
        c.is_last   = 1'b0;
        c.is_empty  = 1'b0;
        owed_chars.push_back(c);
      end
      dig = digits[n_dig - 1 - i];
      if (dig >= RW'(36)) begin
        c.char_code = rdse_pkg::ASCII_UPPER + CW'(dig - RW'(36));
      end else if (dig >= RW'(10)) begin
        c.char_code = rdse_pkg::ASCII_LOWER + CW'(dig - RW'(10));
      end else begin
        c.char_code = rdse_pkg::ASCII_DIGIT0 + CW'(dig);
      end
      c.is_last  = (i == n_dig - 1);
      c.is_empty = 1'b0;
      owed_chars.push_back(c);
    end
  endfunction

  // Predict on number transactions, compare on character transactions
  always @(posedge clk_i or negedge rst_ni) begin : watch
    char_t got;
    char_t want;
    if (!rst_ni) begin
      owed_chars.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        queue_digit_string(in_mon_i.value, in_mon_i.radix);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.char_code = out_mon_i.char_code;
        got.is_last   = out_mon_i.is_last;
        got.is_empty  = out_mon_i.is_empty;
        if (owed_chars.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected character code=%0d last=%0b empty=%0b",
                     $realtime, got.char_code, got.is_last, got.is_empty);
          end
          mismatches++;
        end else begin
          want = owed_chars.pop_front();
          if (got.char_code !== want.char_code || got.is_last !== want.is_last ||
              got.is_empty !== want.is_empty) begin
            if (mismatches < 10) begin
              $display("%0t: character mismatch:", $realtime,
                       " expected code=%0d last=%0b empty=%0b,",
                       want.char_code, want.is_last, want.is_empty,
                       " got code=%0d last=%0b empty=%0b",
                       got.char_code, got.is_last, got.is_empty);
            end
            mismatches++;
          end
        end
      end
      fail_cnt_o <= mismatches;
      pending_o  <= owed_chars.size();
    end
  end

endmodule

>>> verif/tb.sv
// Top of the radix digit string encoder testbench: clock, reset, number
// stimulus, random output stalls and the verdict.
// Depends on rdse_pkg, rdse_if, rdse_checker and radix_digit_string_encoder_core.
`timescale 1ns / 1ps

module tb;

  localparam int VW = rdse_pkg::VALUE_W;
  localparam int RW = rdse_pkg::RADIX_W;

  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int          RANDOM_ITEMS = 100;

  localparam logic [VW-1:0] VALUE_MAX = {VW{1'b1}};

  logic        clk;
  logic        rst_n;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned ready_left = 0;

  rdse_in_if  in_ch ();
  rdse_out_if out_ch ();

  radix_digit_string_encoder_core uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  rdse_checker chk (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_mon_i  (in_ch),
    .out_mon_i (out_ch),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: pick_gap = 0;
      5, 6, 7:       pick_gap = $urandom_range(1, 3);
      8:             pick_gap = $urandom_range(4, 12);
      default:       pick_gap = $urandom_range(20, 60);
    endcase
  endfunction

  // Random number of random bit length, so every bit toggles
  function automatic logic [VW-1:0] random_number();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    random_number = VW'(raw) >> $urandom_range(0, VW - 1);
  endfunction

  // Offer one number and hold it until the block takes it
  task automatic send_number(input logic [VW-1:0] number,
                             input logic [RW-1:0] radix);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= number;
    in_ch.radix <= radix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Output stalls: phases of random length, including long stall-free runs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (ready_left != 0) begin
      ready_left--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          out_ch.ready <= 1'b1;
          ready_left = $urandom_range(0, 7);
        end
        6, 7: begin
          out_ch.ready <= 1'b0;
          ready_left = $urandom_range(0, 2);
        end
        8: begin
          out_ch.ready <= 1'b0;
          ready_left = $urandom_range(10, 40);
        end
        default: begin
          out_ch.ready <= 1'b1;
          ready_left = $urandom_range(50, 150);
        end
      endcase
    end
  end

  // Reset, directed numbers, random numbers, drain, verdict
  initial begin
    logic [RW-1:0] radix;
    logic [VW-1:0] number;
    rst_n = 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    in_ch.radix  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero, with legal and out-of-range bases
    send_number('0, RW'(10));
    send_number('0, RW'(0));
    send_number('0, RW'(63));
    // Single digits and the edges of each character class
    send_number(VW'(1), RW'(2));
    send_number(VW'(9), RW'(10));
    send_number(VW'(10), RW'(11));
    send_number(VW'(35), RW'(36));
    send_number(VW'(36), RW'(62));
    send_number(VW'(61), RW'(62));
    send_number(VW'(61 * 62 + 35), RW'(62));
    // Largest number in the extreme bases, clamped bases too
    send_number(VALUE_MAX, RW'(2));
    send_number(VALUE_MAX, RW'(62));
    send_number(VALUE_MAX, RW'(63));
    send_number(VALUE_MAX, RW'(0));
    send_number(VALUE_MAX, RW'(1));
    send_number(VALUE_MAX, RW'(10));
    send_number(VALUE_MAX, RW'(36));
    send_number(VALUE_MAX, RW'(3));
    // Around the line break: 44 digits has none, 45 has one
    send_number(VW'(1) << 43, RW'(2));
    send_number((VW'(1) << 44) - VW'(1), RW'(2));
    send_number(VW'(1) << 44, RW'(2));
    send_number(VW'(64'd12345678901234), RW'(16));

    // Random numbers, mostly legal bases
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 9) == 0) radix = RW'($urandom_range(0, 63));
      else radix = RW'($urandom_range(2, 62));
      if ($urandom_range(0, 11) == 0) number = '0;
      else number = random_number();
      send_number(number, radix);
    end
    in_ch.valid <= 1'b0;

    // Drain, then leave room for stray characters
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rdse_pkg.sv
hdl/rdse_if.sv
hdl/rdse_divider.sv
hdl/radix_digit_string_encoder_core.sv
verif/rdse_checker.sv
verif/tb.sv
